FILE: sv/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; used by the top level and its checker.
package u2u_pkg;

	typedef enum logic [1:0] {
		HALT_NONE  = 2'd0,
		HALT_STRAY = 2'd1,
		HALT_FULL  = 2'd2
	} halt_t;

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
	localparam logic [7:0]  CONT_MASK      = 8'hC0;
	localparam logic [7:0]  CONT_PREFIX    = 8'h80;
	localparam logic [5:0]  PAYLOAD_MASK   = 6'h3F;
	localparam logic [16:0] UNIT_BYTES     = 17'd2;

endpackage

FILE: sv/utf8_to_ucs2_decoder.sv
// UTF-8 to UCS-2 decoder top level: input register, decode logic, result register.
// Depends on u2u_pkg.
//
// One UTF-8 byte enters per transaction; the byte marked is_last ends the string.
// A byte is taken every clock cycle while the result side keeps up: the byte is
// held in an input stage, decoded against the sequence state, and any result is
// placed in an output register that can wait for out_ready while the next byte
// enters. A result is registered there when its byte leaves the input stage,
// which waits while out_ready holds back the result before it. The capacity
// register must be written through the cfg channel only while no string is in
// flight (the block itself does not enforce this); after reset it holds 65535.
module utf8_to_ucs2_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] output_capacity_bytes,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  utf8_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        unit_valid,
	output logic        malformed,
	output logic        done_res,
	output logic [1:0]  halt_cause,
	output logic [15:0] output_bytes
);
	import u2u_pkg::*;

	logic [15:0] capacity_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	logic [2:0]  pending_q;
	logic [15:0] acc_q;
	logic        bad_q;
	logic [15:0] count_q;
	halt_t       halted_q;

	logic [2:0]  pending_d;
	logic [15:0] acc_d;
	logic        bad_d;
	logic [15:0] count_d;
	halt_t       halted_d;
	logic        emit;
	logic [15:0] unit_d;
	logic        uvalid_d;
	logic        malf_d;

	logic        out_valid_q;
	logic [15:0] unit_q;
	logic        uvalid_q;
	logic        malf_q;
	logic        done_q;
	halt_t       cause_q;
	logic [15:0] obytes_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= output_capacity_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= utf8_byte;
			last_s1 <= is_last;
		end
	end

	always_comb begin
		logic complete;
		logic new_halt;
		logic [16:0] next_count;
		complete  = 1'b0;
		new_halt  = 1'b0;
		pending_d = pending_q;
		acc_d     = acc_q;
		bad_d     = bad_q;
		count_d   = count_q;
		halted_d  = halted_q;
		unit_d    = 16'h0000;
		uvalid_d  = 1'b0;
		malf_d    = 1'b0;
		next_count = {1'b0, count_q} + UNIT_BYTES;
		if (halted_q == HALT_NONE) begin
			if (pending_q == 3'd0) begin
				case (byte_s1) inside
					[8'h00:8'h7F]: begin
						acc_d    = {8'h00, byte_s1};
						bad_d    = 1'b0;
						complete = 1'b1;
					end
					[8'h80:8'hBF]: begin
						halted_d = HALT_STRAY;
						new_halt = 1'b1;
					end
					[8'hC0:8'hDF]: begin
						pending_d = 3'd1;
						acc_d     = {11'd0, byte_s1[4:0]};
						bad_d     = 1'b0;
					end
					[8'hE0:8'hEF]: begin
						pending_d = 3'd2;
						acc_d     = {12'd0, byte_s1[3:0]};
						bad_d     = 1'b0;
					end
					[8'hF0:8'hF7]: begin
						pending_d = 3'd3;
						acc_d     = {13'd0, byte_s1[2:0]};
						bad_d     = 1'b0;
					end
					[8'hF8:8'hFB]: begin
						pending_d = 3'd4;
						acc_d     = {14'd0, byte_s1[1:0]};
						bad_d     = 1'b0;
					end
					default: begin
						pending_d = 3'd5;
						acc_d     = {15'd0, byte_s1[0]};
						bad_d     = 1'b0;
					end
				endcase
			end else begin
				if ((byte_s1 & CONT_MASK) != CONT_PREFIX) begin
					bad_d = 1'b1;
				end
				acc_d     = {acc_q[9:0], byte_s1[5:0] & PAYLOAD_MASK};
				pending_d = pending_q - 3'd1;
				if (pending_d == 3'd0) begin
					complete = 1'b1;
				end
			end

			if (!complete && !new_halt && last_s1 && pending_d != 3'd0) begin
				bad_d    = 1'b1;
				complete = 1'b1;
			end

			if (complete) begin
				malf_d = bad_d;
				if (next_count > {1'b0, capacity_q}) begin
					halted_d = HALT_FULL;
					new_halt = 1'b1;
				end else begin
					count_d  = next_count[15:0];
					unit_d   = bad_d ? 16'h0000 : acc_d;
					uvalid_d = 1'b1;
				end
				pending_d = 3'd0;
				acc_d     = 16'h0000;
				bad_d     = 1'b0;
			end
		end
		emit = complete || new_halt || last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
			acc_q     <= 16'h0000;
			bad_q     <= 1'b0;
			count_q   <= 16'h0000;
			halted_q  <= HALT_NONE;
		end else if (advance) begin
			if (last_s1) begin
				pending_q <= 3'd0;
				acc_q     <= 16'h0000;
				bad_q     <= 1'b0;
				count_q   <= 16'h0000;
				halted_q  <= HALT_NONE;
			end else begin
				pending_q <= pending_d;
				acc_q     <= acc_d;
				bad_q     <= bad_d;
				count_q   <= count_d;
				halted_q  <= halted_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			unit_q   <= unit_d;
			uvalid_q <= uvalid_d;
			malf_q   <= malf_d;
			done_q   <= last_s1;
			cause_q  <= halted_d;
			obytes_q <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign code_unit    = unit_q;
	assign unit_valid   = uvalid_q;
	assign malformed    = malf_q;
	assign done_res     = done_q;
	assign halt_cause   = cause_q;
	assign output_bytes = obytes_q;

endmodule

FILE: sv/u2u_checker.sv
// Port-level checker for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends on u2u_pkg and utf8_to_ucs2_decoder.
module u2u_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        unit_valid,
	input logic        malformed,
	input logic [1:0]  halt_cause,
	input logic [15:0] output_bytes
);
	import u2u_pkg::*;

	// hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(output_bytes))
		else $error("result changed while stalled");

	a_bad_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (malformed || !unit_valid) |-> code_unit == 16'h0000)
		else $error("malformed or absent unit is not zero");

	a_unit_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unit_valid |-> halt_cause == HALT_NONE)
		else $error("unit written while halted");

	a_cause_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> halt_cause == HALT_NONE || halt_cause == HALT_STRAY
			|| halt_cause == HALT_FULL)
		else $error("undefined halt cause");

	a_count_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> output_bytes[0] == 1'b0)
		else $error("odd output byte count");

endmodule

bind utf8_to_ucs2_decoder u2u_checker u_u2u_checker (.*);
